### hdl/itr_pkg.sv
// Shared constants and the digit character function for the radix text converter.
package itr_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W = 7;
  localparam int DIV_STEPS = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] DECIMAL_RADIX = 6'd10;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CHAR = 7'h30;
  localparam logic [CHAR_W-1:0] ALPHA_CHAR = 7'h41;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = ZERO_CHAR + {1'b0, d};
    end else begin
      c = ALPHA_CHAR + {1'b0, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

### hdl/itr_front.sv
// Front end: accepts a value, decides on the minus sign and forms the magnitude.
module itr_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic [itr_pkg::RADIX_W-1:0] radix,
  input  logic                        value_valid,
  output logic                        value_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                        full,
  output logic                        push,
  output logic                        neg,
  output logic [VALUE_WIDTH-1:0]      mag
);

  assign neg = (radix == itr_pkg::DECIMAL_RADIX) && value[VALUE_WIDTH-1];
  assign mag = neg ? VALUE_WIDTH'(-value) : VALUE_WIDTH'(value);
  assign push = value_valid && !full;
  assign value_stall = full;

endmodule

### hdl/itr_fifo.sv
// Two-entry queue between the front end and the conversion engine.
module itr_fifo #(
  parameter int DATA_W = 33
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rdata = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

### hdl/itr_back.sv
// Conversion engine: iterative division by the radix, digit buffer and output register.
module itr_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [itr_pkg::RADIX_W-1:0]  radix,
  input  logic                         item_valid,
  input  logic                         item_neg,
  input  logic [VALUE_WIDTH-1:0]       item_mag,
  output logic                         item_pop,
  output logic                         text_valid,
  input  logic                         text_stall,
  output logic [itr_pkg::CHAR_W-1:0]   text_char,
  output logic                         last
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    IDLE,
    DIV,
    SIGN,
    RD,
    LD
  } state_t;

  state_t                       state;
  logic [VALUE_WIDTH-1:0]       dvd;
  logic [itr_pkg::RADIX_W-1:0]  rem;
  logic [CNT_W-1:0]             bits_left;
  logic [CNT_W-1:0]             nd;
  logic [IDX_W-1:0]             rd_idx;
  logic                         neg;
  logic [itr_pkg::CHAR_W-1:0]   rdata;
  logic [itr_pkg::CHAR_W-1:0]   mem [VALUE_WIDTH];

  logic [VALUE_WIDTH-1:0]       div_dvd;
  logic [itr_pkg::RADIX_W-1:0]  div_rem;
  logic [CNT_W-1:0]             bits_left_next;
  logic [CNT_W-1:0]             nd_next;
  logic                         digit_done;
  logic                         out_free;
  logic                         emit;

  assign item_pop = (state == IDLE) && item_valid;
  assign out_free = !text_valid || !text_stall;
  assign nd_next = nd + 1'b1;
  assign emit = ((state == SIGN) && neg) || (state == LD);

  // Restoring division, up to DIV_STEPS quotient bits per cycle.
  always_comb begin
    logic [itr_pkg::RADIX_W:0] t;
    div_dvd = dvd;
    div_rem = rem;
    for (int k = 0; k < itr_pkg::DIV_STEPS; k++) begin
      t = {div_rem, div_dvd[VALUE_WIDTH-1]};
      if (CNT_W'(k) < bits_left) begin
        if (t >= {1'b0, radix}) begin
          div_rem = itr_pkg::RADIX_W'(t - {1'b0, radix});
          div_dvd = {div_dvd[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          div_rem = t[itr_pkg::RADIX_W-1:0];
          div_dvd = {div_dvd[VALUE_WIDTH-2:0], 1'b0};
        end
      end
    end
    if (bits_left > CNT_W'(itr_pkg::DIV_STEPS)) begin
      bits_left_next = bits_left - CNT_W'(itr_pkg::DIV_STEPS);
    end else begin
      bits_left_next = '0;
    end
    digit_done = (bits_left_next == '0);
  end

  always_ff @(posedge clk) begin
    if (state == DIV && digit_done) begin
      mem[nd[IDX_W-1:0]] <= itr_pkg::digit_char(div_rem);
    end
    rdata <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      text_valid <= 1'b0;
    end else begin
      if (out_free) begin
        text_valid <= emit;
      end
      unique case (state)
        IDLE: begin
          if (item_valid) begin
            dvd <= item_mag;
            rem <= '0;
            bits_left <= CNT_W'(VALUE_WIDTH);
            nd <= '0;
            neg <= item_neg;
            state <= DIV;
          end
        end
        DIV: begin
          dvd <= div_dvd;
          if (digit_done) begin
            nd <= nd_next;
            rem <= '0;
            bits_left <= CNT_W'(VALUE_WIDTH);
            if (div_dvd == '0 || nd_next == CNT_W'(VALUE_WIDTH)) begin
              rd_idx <= nd[IDX_W-1:0];
              state <= SIGN;
            end
          end else begin
            rem <= div_rem;
            bits_left <= bits_left_next;
          end
        end
        SIGN: begin
          if (!neg) begin
            state <= RD;
          end else if (out_free) begin
            text_char <= itr_pkg::MINUS_CHAR;
            last <= 1'b0;
            state <= RD;
          end
        end
        RD: begin
          state <= LD;
        end
        LD: begin
          if (out_free) begin
            text_char <= rdata;
            last <= (rd_idx == '0);
            if (rd_idx == '0) begin
              state <= IDLE;
            end else begin
              rd_idx <= rd_idx - 1'b1;
              state <= RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### hdl/integer_to_text_radix_core.sv
// The engine divides the magnitude by the radix once per digit and buffers each digit,
// then sends the minus sign, when one leads, and the digits most significant first;
// each digit is read from the buffer (RD) and loaded into the output register (LD).
// The engine takes a new value only once the last one is sent; a two-entry queue feeds it.
// Reset: synchronous, active high; clears control state and sets radix to 10.
module integer_to_text_radix_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [itr_pkg::RADIX_W-1:0]  cfg_wdata,
  input  logic                         value_valid,
  output logic                         value_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                         text_valid,
  input  logic                         text_stall,
  output logic [itr_pkg::CHAR_W-1:0]   text_char,
  output logic                         last
);

  logic [itr_pkg::RADIX_W-1:0] radix;
  logic [itr_pkg::RADIX_W-1:0] radix_next;
  logic                        push;
  logic                        full;
  logic                        front_neg;
  logic [VALUE_WIDTH-1:0]      front_mag;
  logic                        pop;
  logic                        not_empty;
  logic [VALUE_WIDTH:0]        q_rdata;

  always_comb begin
    if (cfg_wdata < itr_pkg::RADIX_MIN) begin
      radix_next = itr_pkg::RADIX_MIN;
    end else if (cfg_wdata > itr_pkg::RADIX_MAX) begin
      radix_next = itr_pkg::RADIX_MAX;
    end else begin
      radix_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itr_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix <= radix_next;
    end
  end

  itr_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .radix       (radix),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .full        (full),
    .push        (push),
    .neg         (front_neg),
    .mag         (front_mag)
  );

  itr_fifo #(.DATA_W(VALUE_WIDTH + 1)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     ({front_neg, front_mag}),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rdata     (q_rdata)
  );

  itr_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .radix      (radix),
    .item_valid (not_empty),
    .item_neg   (q_rdata[VALUE_WIDTH]),
    .item_mag   (q_rdata[VALUE_WIDTH-1:0]),
    .item_pop   (pop),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_char  (text_char),
    .last       (last)
  );

endmodule

### hdl/itr_checker.sv
// Port-level checks on the text output channel, bound to the top level.
module itr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       text_valid,
  input logic                       text_stall,
  input logic [itr_pkg::CHAR_W-1:0] text_char,
  input logic                       last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_stall |=> text_valid)
    else $error("text_valid dropped during stall");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_stall |=> $stable(text_char) && $stable(last))
    else $error("text payload changed during stall");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !text_valid)
    else $error("text_valid high after reset");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_char == itr_pkg::MINUS_CHAR |-> !last)
    else $error("minus sign marked as last character");

endmodule

bind integer_to_text_radix_core itr_checker u_itr_checker (
  .clk        (clk),
  .rst        (rst),
  .text_valid (text_valid),
  .text_stall (text_stall),
  .text_char  (text_char),
  .last       (last)
);
